@@ rtl/core/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the sine series unit
// Field widths, sequencing constants, the control bundle between the
// sequencer and the arithmetic unit, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Series limits and fixed-point format.
    localparam int MAX_TERMS  = 24;
    localparam int FRAC_BITS  = 32;
    localparam int TERM_RESET = 8;

    // Field widths.
    localparam int TC_W   = 5;    // term count register
    localparam int ANG_W  = 5;    // signed integer argument
    localparam int XMAG_W = 5;    // argument magnitude, up to 16
    localparam int SQ_W   = 9;    // magnitude squared, up to 256
    localparam int MAG_W  = 63;   // term magnitude, held at 2^63-1
    localparam int SUM_W  = 64;   // signed running sum
    localparam int PROD_W = MAG_W + SQ_W;

    // Term index and per-term divisor (2k-2)(2k-1).
    localparam int K_W     = $clog2(MAX_TERMS + 1);
    localparam int DIV_MAX = (2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1);
    localparam int DIV_W   = $clog2(DIV_MAX + 1);

    // Long division retires this many quotient bits per cycle.
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (PROD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DC_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // Control bundle from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic           load;        // take a new argument, form term one
        logic           term_start;  // multiply by x squared, set up divisor
        logic           div_step;    // retire one group of quotient bits
        logic           accumulate;  // cap the quotient and add it to the sum
        logic [K_W-1:0] term_index;  // index k of the term being formed
    } sts_ctrl_t;

    // Divisor for term k: (2k-2)(2k-1).
    function automatic logic [DIV_W-1:0] term_divisor(input logic [K_W-1:0] k);
        logic [DIV_W-1:0] a;
        logic [DIV_W-1:0] b;
        a = DIV_W'({k, 1'b0}) - DIV_W'(2);
        b = DIV_W'({k, 1'b0}) - DIV_W'(1);
        return DIV_W'(a * b);
    endfunction

    // Adds or subtracts a magnitude, clamping at the signed 64-bit limits.
    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0] sum,
        input logic [MAG_W-1:0] mag,
        input logic             negative
    );
        logic [SUM_W:0] ext;
        logic [SUM_W:0] m;
        m   = (SUM_W + 1)'(mag);
        ext = negative ? ({sum[SUM_W-1], sum} - m) : ({sum[SUM_W-1], sum} + m);
        if (ext[SUM_W] != ext[SUM_W-1]) begin
            return ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return ext[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/core/sts_arith_unit.sv @@
// ----------------------------------------------------------------------------
// sts_arith_unit: shared multiply, divide and accumulate unit
// Holds the argument, the current term and the running sum. Each term is
// the previous one times x squared, divided by (2k-2)(2k-1) through a long
// division that retires several quotient bits per cycle, then capped and
// added into the saturating sum.
// ----------------------------------------------------------------------------
module sts_arith_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sts_pkg::sts_ctrl_t               ctrl,
    input  logic signed [sts_pkg::ANG_W-1:0] angle_int,
    output logic signed [sts_pkg::SUM_W-1:0] sum
);
    import sts_pkg::*;

    logic                xneg_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic [XMAG_W-1:0]   xmag;
    logic [MAG_W-1:0]    mag_first;
    logic [PROD_W-1:0]   prod_next;
    logic [DIV_W-1:0]    rem_next;
    logic [DIV_W:0]      trial;
    logic [MAG_W-1:0]    mag_capped;
    logic                term_neg;

    // Magnitude of the argument and the first term |x| * 2^FRAC_BITS.
    assign xmag      = angle_int[ANG_W-1] ? XMAG_W'(-angle_int) : XMAG_W'(angle_int);
    assign mag_first = MAG_W'(xmag) << FRAC_BITS;

    // Even terms flip the sign of the argument.
    assign term_neg = xneg_reg ^ ~ctrl.term_index[0];

    // Quotient bits at or above bit 63 mean the term is held at its cap.
    assign mag_capped = (|prod_reg[PROD_W-1:MAG_W]) ? {MAG_W{1'b1}} : prod_reg[MAG_W-1:0];

    // One group of restoring division steps; the remainder stays narrow.
    always_comb
    begin
        rem_next  = rem_reg;
        prod_next = prod_reg;
        trial     = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial     = {rem_next, prod_next[PROD_W-1]};
            prod_next = {prod_next[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next     = DIV_W'(trial - {1'b0, div_reg});
                prod_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
        end
    end

    // Argument sign is control state; the rest is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xneg_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            xneg_reg <= angle_int[ANG_W-1];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sq_reg  <= SQ_W'(xmag) * SQ_W'(xmag);
            mag_reg <= mag_first;
            sum_reg <= angle_int[ANG_W-1] ? -SUM_W'(mag_first) : SUM_W'(mag_first);
        end
        if (ctrl.term_start)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(sq_reg);
            rem_reg  <= '0;
            div_reg  <= term_divisor(ctrl.term_index);
        end
        if (ctrl.div_step)
        begin
            prod_reg <= prod_next;
            rem_reg  <= rem_next;
        end
        if (ctrl.accumulate)
        begin
            mag_reg <= mag_capped;
            sum_reg <= sat_add(sum_reg, mag_capped, term_neg);
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/core/sts_sequencer.sv @@
// ----------------------------------------------------------------------------
// sts_sequencer: term sequencer and output register
// Takes an argument beat, steps the arithmetic unit through each term
// (multiply, division cycles, accumulate), and hands the sum to the output
// register. Also holds the term count register.
// ----------------------------------------------------------------------------
module sts_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sts_pkg::TC_W-1:0]         term_count,
    input  logic signed [sts_pkg::SUM_W-1:0] sum,
    output sts_pkg::sts_ctrl_t               ctrl,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [sts_pkg::SUM_W-1:0] sine_value
);
    import sts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [TC_W-1:0]   term_count_reg;
    logic [K_W-1:0]    terms_reg;
    logic [K_W-1:0]    k_reg;
    logic [DC_W-1:0]   div_cnt_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  sine_value_reg;

    logic              in_fire;
    logic              out_load;
    logic [K_W-1:0]    terms_clamped;
    logic [K_W-1:0]    tc_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Zero terms counts as one; the count is held at the maximum.
    assign tc_ext = K_W'(term_count_reg);
    always_comb
    begin
        if (tc_ext == '0)
        begin
            terms_clamped = K_W'(1);
        end
        else if (tc_ext > K_W'(MAX_TERMS))
        begin
            terms_clamped = K_W'(MAX_TERMS);
        end
        else
        begin
            terms_clamped = tc_ext;
        end
    end

    // Strobes to the arithmetic unit.
    always_comb
    begin
        ctrl.load       = in_fire;
        ctrl.term_start = (state_reg == ST_MUL);
        ctrl.div_step   = (state_reg == ST_DIV);
        ctrl.accumulate = (state_reg == ST_ACC);
        ctrl.term_index = k_reg;
    end

    // Term count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TC_W'(TERM_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            term_count_reg <= term_count;
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            terms_reg     <= K_W'(1);
            k_reg         <= K_W'(2);
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        terms_reg <= terms_clamped;
                        k_reg     <= K_W'(2);
                        state_reg <= (terms_clamped == K_W'(1)) ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DC_W'(1);
                    if (div_cnt_reg == DC_W'(DIV_CYCLES - 1))
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    if (k_reg == terms_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sine_value_reg <= sum;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sine_value = sine_value_reg;

    // An accepted argument starts a run and drops ready.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("ready stayed high after an argument beat");

    // The term index never passes the clamped term count while terms are formed.
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_DONE) |->
            (k_reg <= terms_reg && k_reg >= K_W'(2)))
        else $error("term index out of range");

    // The division counter stays within its cycle count.
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg <= DC_W'(DIV_CYCLES - 1)))
        else $error("division counter overran");

    // Leaving the done state always presents a result.
    a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && (state_reg == ST_IDLE))
        else $error("result not presented after the run");

endmodule

@@ rtl/core/sine_taylor_series_unit.sv @@
// ----------------------------------------------------------------------------
// N is the clamped term count (1 to 24). Each term takes a multiply step,
// the long division steps and an add step on the shared arithmetic unit;
// one argument is in work at a time.
// A waiting result is held in the output register while ready returns.
// Reset (rst_n low, asynchronous) sets the term count to 8 and empties the unit.
// ----------------------------------------------------------------------------
// sine_taylor_series_unit: truncated Maclaurin sine in fixed point
// Sums the first N terms of x - x^3/3! + x^5/5! - ... for a small integer
// argument, with 32 fraction bits and a saturating 64-bit sum.
// ----------------------------------------------------------------------------
module sine_taylor_series_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sts_pkg::TC_W-1:0]         term_count,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [sts_pkg::ANG_W-1:0] angle_int,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [sts_pkg::SUM_W-1:0] sine_value
);
    import sts_pkg::*;

    sts_ctrl_t               ctrl;
    logic signed [SUM_W-1:0] sum;

    // Term sequencer, configuration and output register.
    sts_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .term_count (term_count),
        .sum        (sum),
        .ctrl       (ctrl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sine_value (sine_value)
    );

    // Shared multiply, divide and accumulate unit.
    sts_arith_unit u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .angle_int (angle_int),
        .sum       (sum)
    );

endmodule
